// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescape block: types, character codes and helpers.
`default_nettype none
package jsu_pkg;

	// Decoder mode
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_BODY = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_TAB   = 8'h09;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_FF    = 8'h0C;

	// UTF-8 encoding constants
	localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0]  UTF8_CONT   = 8'h80;
	localparam logic [15:0] UTF8_LIM1   = 16'h0080;
	localparam logic [15:0] UTF8_LIM2   = 16'h0800;
	localparam logic [1:0]  HEX_LAST    = 2'd3;

	// Burst queue geometry
	localparam int QPTR_W  = 1;
	localparam int QDEPTH  = 1 << QPTR_W;
	localparam int QCNT_W  = QPTR_W + 1;

	// Results of one input byte: up to four data bytes, then an optional close
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      ndata;
		logic            close;
	} burst_t;

	// Hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (b >= 8'h30 && b <= 8'h39) begin
				r = {1'b1, 4'(b - 8'h30)};
			end else if (b >= 8'h61 && b <= 8'h66) begin
				r = {1'b1, 4'(b - 8'h57)};
			end else if (b >= 8'h41 && b <= 8'h46) begin
				r = {1'b1, 4'(b - 8'h37)};
			end
			return r;
		end
	endfunction

	// Encode a code point as one to three UTF-8 bytes
	function automatic burst_t utf8_burst(input logic [15:0] code);
		burst_t r;
		begin
			r = '0;
			if (code < UTF8_LIM1) begin
				r.data[0] = code[7:0];
				r.ndata   = 3'd1;
			end else if (code < UTF8_LIM2) begin
				r.data[0] = UTF8_LEAD2 | {3'b000, code[10:6]};
				r.data[1] = UTF8_CONT | {2'b00, code[5:0]};
				r.ndata   = 3'd2;
			end else begin
				r.data[0] = UTF8_LEAD3 | {4'b0000, code[15:12]};
				r.data[1] = UTF8_CONT | {2'b00, code[11:6]};
				r.data[2] = UTF8_CONT | {2'b00, code[5:0]};
				r.ndata   = 3'd3;
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jsu_in_if.sv =====
// Text byte channel: valid/ready handshake carrying one input byte.
`default_nettype none
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/jsu_out_if.sv =====
// Result channel: valid/ready handshake carrying one decoded byte and flags.
`default_nettype none
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       string_end;
	logic       last;

	modport source(output valid, output out_byte, output string_end, output last, input ready);
	modport sink(input valid, input out_byte, input string_end, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Front end: accepts text bytes, tracks the string mode and builds result bursts.
`default_nettype none
module jsu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	jsu_in_if.sink              text,
	input  wire logic           q_full,
	output logic                push,
	output jsu_pkg::burst_t     burst
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [7:0]     delim_q, delim_d;
	logic [15:0]    hex_code_q, hex_code_d;
	logic [1:0]     hex_count_q, hex_count_d;

	logic [7:0]     b;
	logic           acc;
	logic [4:0]     hx;
	logic           is_hex;
	logic [15:0]    code_next;
	logic           is_close;
	logic           is_bslash;
	jsu_pkg::burst_t br;

	// Classify the incoming byte
	assign text.ready = !q_full;
	assign acc        = text.valid && text.ready;
	assign b          = text.text_byte;
	assign hx         = jsu_pkg::hex_nibble(b);
	assign is_hex     = hx[4];
	assign code_next  = {hex_code_q[11:0], hx[3:0]};
	assign is_close   = (b == jsu_pkg::CH_NUL) || (b == delim_q);
	assign is_bslash  = (b == jsu_pkg::CH_BSLASH);

	// Next state
	always_comb begin
		mode_d      = mode_q;
		delim_d     = delim_q;
		hex_code_d  = hex_code_q;
		hex_count_d = hex_count_q;
		if (acc) begin
			unique case (mode_q)
				jsu_pkg::MODE_IDLE: begin
					if (b != jsu_pkg::CH_NUL) begin
						delim_d = b;
						mode_d  = jsu_pkg::MODE_BODY;
					end
				end
				jsu_pkg::MODE_BODY: begin
					if (is_close) begin
						mode_d = jsu_pkg::MODE_IDLE;
					end else if (is_bslash) begin
						mode_d = jsu_pkg::MODE_ESC;
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (b == jsu_pkg::CH_NUL) begin
						mode_d = jsu_pkg::MODE_IDLE;
					end else if (b == jsu_pkg::CH_U) begin
						mode_d      = jsu_pkg::MODE_HEX;
						hex_code_d  = '0;
						hex_count_d = '0;
					end else begin
						mode_d = jsu_pkg::MODE_BODY;
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (is_hex && hex_count_q != jsu_pkg::HEX_LAST) begin
						hex_code_d  = code_next;
						hex_count_d = 2'(hex_count_q + 2'd1);
					end else begin
						hex_code_d  = '0;
						hex_count_d = '0;
						if (is_hex) begin
							mode_d = jsu_pkg::MODE_BODY;
						end else if (is_close) begin
							mode_d = jsu_pkg::MODE_IDLE;
						end else if (is_bslash) begin
							mode_d = jsu_pkg::MODE_ESC;
						end else begin
							mode_d = jsu_pkg::MODE_BODY;
						end
					end
				end
				default: mode_d = jsu_pkg::MODE_IDLE;
			endcase
		end
	end

	// Burst contents for the byte at the input
	always_comb begin
		br = '0;
		unique case (mode_q)
			jsu_pkg::MODE_IDLE: br = '0;
			jsu_pkg::MODE_BODY: begin
				if (is_close) begin
					br.close = 1'b1;
				end else if (!is_bslash) begin
					br.data[0] = b;
					br.ndata   = 3'd1;
				end
			end
			jsu_pkg::MODE_ESC: begin
				br.ndata = 3'd1;
				unique case (b)
					jsu_pkg::CH_NUL: begin
						br.data[0] = jsu_pkg::CH_BSLASH;
						br.close   = 1'b1;
					end
					jsu_pkg::CH_N: br.data[0] = jsu_pkg::CTL_LF;
					jsu_pkg::CH_T: br.data[0] = jsu_pkg::CTL_TAB;
					jsu_pkg::CH_R: br.data[0] = jsu_pkg::CTL_CR;
					jsu_pkg::CH_B: br.data[0] = jsu_pkg::CTL_BS;
					jsu_pkg::CH_F: br.data[0] = jsu_pkg::CTL_FF;
					jsu_pkg::CH_U: br.ndata   = 3'd0;
					default:       br.data[0] = b;
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				if (is_hex) begin
					if (hex_count_q == jsu_pkg::HEX_LAST) begin
						br = jsu_pkg::utf8_burst(code_next);
					end
				end else begin
					// Short escape: flush the code point, then treat the byte as body
					br = jsu_pkg::utf8_burst(hex_code_q);
					if (is_close) begin
						br.close = 1'b1;
					end else if (!is_bslash) begin
						br.data[br.ndata[1:0]] = b;
						br.ndata               = 3'(br.ndata + 3'd1);
					end
				end
			end
			default: br = '0;
		endcase
	end

	assign burst = br;
	assign push  = acc && ((br.ndata != 3'd0) || br.close);

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= jsu_pkg::MODE_IDLE;
			delim_q     <= '0;
			hex_code_q  <= '0;
			hex_count_q <= '0;
		end else begin
			mode_q      <= mode_d;
			delim_q     <= delim_d;
			hex_code_q  <= hex_code_d;
			hex_count_q <= hex_count_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jsu_queue.sv =====
// Short queue of result bursts between the front end and the back end.
`default_nettype none
module jsu_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire jsu_pkg::burst_t      push_data,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      empty,
	output jsu_pkg::burst_t           head
);

	jsu_pkg::burst_t                    entries_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [jsu_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [jsu_pkg::QCNT_W-1:0]         count_q;

	assign full  = (count_q == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Store a request
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= jsu_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= jsu_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= jsu_pkg::QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= jsu_pkg::QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Back end: walks the burst at the queue head and emits one result per cycle while the receiver is ready.
`default_nettype none
module jsu_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             empty,
	input  wire jsu_pkg::burst_t  head,
	output logic                  pop,
	jsu_out_if.source             result
);

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_data;
	logic       is_last;

	// Select the result at the current position of the burst
	assign total   = 3'(head.ndata + {2'b00, head.close});
	assign is_data = ({1'b0, idx_q} < head.ndata);
	assign is_last = (3'({1'b0, idx_q} + 3'd1) == total);

	assign result.valid      = !empty;
	assign result.out_byte   = is_data ? head.data[idx_q] : 8'h00;
	assign result.string_end = !is_data;
	assign result.last       = is_last;

	assign pop = result.valid && result.ready && is_last;

	// Advance within the burst, restart on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (result.valid && result.ready) begin
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/json_string_unescape_utf8_core.sv =====
// JSON string unescape core: decodes a quoted string byte by byte to UTF-8 bytes.
//
// Channels: text carries one input byte per request (text_byte, 0 = end of text);
// result carries one decoded byte per request with string_end and last flags.
// The first nonzero byte seen while idle is taken as the closing delimiter.
// The results of a byte are registered in the queue before the result channel
// offers them. Throughput: one text byte per cycle while the receiver is ready and
// each byte yields at most one result; a byte yielding several results (up to four,
// from a u escape) holds the result channel, one result per cycle while ready.
// The front end decodes combinationally and writes each byte's results as one
// burst into a two-entry queue; the back end drains it one result per ready cycle.
// text.ready drops only when the queue is full, so a stalled receiver backs up
// at most two bytes of work before input is held off; nothing is lost.
// Reset (arst_n low) empties the queue and returns the decoder to idle.
`default_nettype none
module json_string_unescape_utf8_core (
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source result
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	jsu_pkg::burst_t burst;
	jsu_pkg::burst_t head;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_full (q_full),
		.push   (push),
		.burst  (burst)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (burst),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== rtl/jsu_checker.sv =====
// Port checker for the JSON string unescape core, bound to the top level.
`default_nettype none
module jsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] res_byte,
	input wire logic       res_end,
	input wire logic       res_last
);

	// A close result carries a zero byte
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_end |-> res_byte == 8'h00)
		else $error("string_end result with nonzero byte");

	// A close is always the final result of its input byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_end |-> res_last)
		else $error("string_end result not marked last");

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(res_byte) && $stable(res_end) && $stable(res_last))
		else $error("result payload changed while stalled");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_byte  (result.out_byte),
	.res_end   (result.string_end),
	.res_last  (result.last)
);
`default_nettype wire
